### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the UTF-8 line scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/u8les_pkg.sv
// Types and constants shared by the UTF-8 line scanner modules.
`timescale 1ns / 1ps
`default_nettype none

package u8les_pkg;

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    // File-wide line ending codes
    localparam logic [2:0] FE_NONE   = 3'd0;
    localparam logic [2:0] FE_LF     = 3'd1;
    localparam logic [2:0] FE_CRLF   = 3'd2;
    localparam logic [2:0] FE_CR     = 3'd3;
    localparam logic [2:0] FE_HYBRID = 3'd4;

    // Per-line ending codes
    localparam logic [1:0] LE_NONE = 2'd0;
    localparam logic [1:0] LE_LF   = 2'd1;
    localparam logic [1:0] LE_CRLF = 2'd2;
    localparam logic [1:0] LE_CR   = 2'd3;

    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [20:0] CP_CR     = 21'h00000D;
    localparam logic [20:0] CP_LF     = 21'h00000A;
    localparam logic [20:0] CP_REPL   = 21'h00FFFD;

    // Result queue geometry
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int MAX_PUSH = 3;

    // Merge a newly seen line ending into the file-wide type.
    function automatic logic [2:0] note_ending(input logic [2:0] seen, input logic [2:0] e);
        logic [2:0] r;
        r = seen;
        if (seen == FE_NONE) begin
            r = e;
        end else if (seen != FE_HYBRID && seen != e) begin
            r = FE_HYBRID;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/u8les_core.sv
// Per-byte UTF-8 decode, line-ending tracking and result record assembly.
`timescale 1ns / 1ps
`default_nettype none

module u8les_core
    import u8les_pkg::*;
#(
    parameter int POSITION_BITS = 24,
    localparam int REC_W = 3 * POSITION_BITS + 40
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_take,
    input  wire logic [7:0]                    i_byte,
    input  wire logic                          i_eob,
    output logic      [1:0]                    o_push_cnt,
    output logic      [MAX_PUSH-1:0][REC_W-1:0] o_recs
);

    logic                     r_crp,      n_crp;
    logic [POSITION_BITS-1:0] r_crpos,    n_crpos;
    logic [1:0]               r_need,     n_need;
    logic [2:0]               r_seqlen,   n_seqlen;
    logic [20:0]              r_part,     n_part;
    logic [7:0]               r_lead,     n_lead;
    logic [POSITION_BITS-1:0] r_lead_pos, n_lead_pos;
    logic [POSITION_BITS-1:0] r_bytes,    n_bytes;
    logic [POSITION_BITS-1:0] r_chars,    n_chars;
    logic [POSITION_BITS:0]   r_u16,      n_u16;
    logic [2:0]               r_fe,       n_fe;
    logic                     r_err,      n_err;

    logic [MAX_PUSH-1:0][REC_W-1:0] s_rec;
    logic [MAX_PUSH-1:0]            s_v;
    logic                           v_done;
    logic                           v_fin;
    logic                           v_fail;
    logic [20:0]                    v_cp;
    logic [POSITION_BITS-1:0]       v_fpos;
    logic [2:0]                     v_flen;
    logic [7:0]                     v_bad;
    logic [7:0]                     v_lo;
    logic [7:0]                     v_hi;
    logic [1:0]                     v_cnt;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [POSITION_BITS:0] u16_add(input logic [POSITION_BITS:0] v,
                                                       input logic [1:0] units);
        logic [POSITION_BITS+1:0] sum;
        sum = {1'b0, v} + (POSITION_BITS + 2)'(units);
        return sum[POSITION_BITS+1] ? '1 : sum[POSITION_BITS:0];
    endfunction

    function automatic logic [REC_W-1:0] make_rec(
        input t_kind                    kind,
        input logic [POSITION_BITS-1:0] bpos,
        input logic [POSITION_BITS-1:0] cpos,
        input logic [POSITION_BITS:0]   upos,
        input logic [20:0]              cp,
        input logic                     lb,
        input logic                     cl,
        input logic [1:0]               le,
        input logic [2:0]               fe,
        input logic [7:0]               bad
    );
        return {1'b0, kind, bad, fe, le, cl, lb, cp, upos, cpos, bpos};
    endfunction

    always_comb begin
        n_crp      = r_crp;
        n_crpos    = r_crpos;
        n_need     = r_need;
        n_seqlen   = r_seqlen;
        n_part     = r_part;
        n_lead     = r_lead;
        n_lead_pos = r_lead_pos;
        n_bytes    = sat_inc(r_bytes);
        n_chars    = r_chars;
        n_u16      = r_u16;
        n_fe       = r_fe;
        n_err      = r_err;
        s_rec      = '0;
        s_v        = '0;
        v_done     = 1'b0;
        v_fin      = 1'b0;
        v_fail     = 1'b0;
        v_cp       = '0;
        v_fpos     = r_bytes;
        v_flen     = 3'd1;
        v_bad      = i_byte;
        v_lo       = 8'h80;
        v_hi       = 8'hBF;

        // Resolve a held CR against this byte
        if (!r_err && r_crp) begin
            n_crp = 1'b0;
            if (i_byte == CH_LF) begin
                n_fe     = note_ending(n_fe, FE_CRLF);
                s_rec[0] = make_rec(KIND_CHAR, r_crpos, n_chars, n_u16, CP_CR,
                                    1'b1, 1'b0, LE_NONE, n_fe, 8'h00);
                s_rec[1] = make_rec(KIND_CHAR, r_bytes, n_chars, n_u16, CP_LF,
                                    1'b1, 1'b1, LE_CRLF, n_fe, 8'h00);
                s_v[1:0] = 2'b11;
                n_chars  = sat_inc(n_chars);
                n_u16    = u16_add(n_u16, 2'd1);
                v_done   = 1'b1;
            end else begin
                n_fe     = note_ending(n_fe, FE_CR);
                s_rec[0] = make_rec(KIND_CHAR, r_crpos, n_chars, n_u16, CP_CR,
                                    1'b1, 1'b1, LE_CR, n_fe, 8'h00);
                s_v[0]   = 1'b1;
                n_chars  = sat_inc(n_chars);
                n_u16    = u16_add(n_u16, 2'd1);
            end
        end

        // Decode the byte itself
        if (!r_err && !v_done) begin
            if (r_need == 2'd0) begin
                if (i_byte == CH_CR) begin
                    if (i_eob) begin
                        n_fe     = note_ending(n_fe, FE_CR);
                        s_rec[1] = make_rec(KIND_CHAR, r_bytes, n_chars, n_u16, CP_CR,
                                            1'b1, 1'b1, LE_CR, n_fe, 8'h00);
                        s_v[1]   = 1'b1;
                        n_chars  = sat_inc(n_chars);
                        n_u16    = u16_add(n_u16, 2'd1);
                    end else begin
                        n_crp   = 1'b1;
                        n_crpos = r_bytes;
                    end
                end else if (i_byte != 8'h00 && i_byte <= 8'h7F) begin
                    v_fin = 1'b1;
                    v_cp  = {13'd0, i_byte};
                end else if ((i_byte >= 8'hC2 && i_byte <= 8'hDF)
                          || (i_byte >= 8'hE0 && i_byte <= 8'hF4)) begin
                    n_lead     = i_byte;
                    n_lead_pos = r_bytes;
                    if (i_byte <= 8'hDF) begin
                        n_need   = 2'd1;
                        n_seqlen = 3'd2;
                        n_part   = {16'd0, i_byte[4:0]};
                    end else if (i_byte <= 8'hEF) begin
                        n_need   = 2'd2;
                        n_seqlen = 3'd3;
                        n_part   = {17'd0, i_byte[3:0]};
                    end else begin
                        n_need   = 2'd3;
                        n_seqlen = 3'd4;
                        n_part   = {18'd0, i_byte[2:0]};
                    end
                    v_fail = i_eob;
                end else begin
                    v_fail = 1'b1;
                end
            end else begin
                // Narrow the first continuation byte after special leads
                if (({1'b0, r_need} + 3'd1) == r_seqlen) begin
                    if (r_lead == 8'hE0) begin
                        v_lo = 8'hA0;
                    end else if (r_lead == 8'hED) begin
                        v_hi = 8'h9F;
                    end else if (r_lead == 8'hF0) begin
                        v_lo = 8'h90;
                    end else if (r_lead == 8'hF4) begin
                        v_hi = 8'h8F;
                    end
                end
                v_bad  = r_lead;
                v_fpos = r_lead_pos;
                if (i_byte < v_lo || i_byte > v_hi) begin
                    v_fail = 1'b1;
                end else begin
                    v_cp   = {r_part[14:0], i_byte[5:0]};
                    n_part = v_cp;
                    n_need = r_need - 2'd1;
                    if (r_need == 2'd1) begin
                        if (v_cp == CP_REPL) begin
                            v_fail = 1'b1;
                        end else begin
                            v_fin  = 1'b1;
                            v_flen = r_seqlen;
                        end
                    end else begin
                        v_fail = i_eob;
                    end
                end
            end
        end

        if (v_fail) begin
            s_rec[1] = make_rec(KIND_ERROR, v_fpos, n_chars, n_u16, 21'd0,
                                1'b0, 1'b0, LE_NONE, n_fe, v_bad);
            s_v[1]   = 1'b1;
            n_err    = 1'b1;
            n_need   = 2'd0;
            n_seqlen = 3'd0;
            n_part   = '0;
        end else if (v_fin) begin
            if (v_cp == CP_LF) begin
                n_fe     = note_ending(n_fe, FE_LF);
                s_rec[1] = make_rec(KIND_CHAR, v_fpos, n_chars, n_u16, v_cp,
                                    1'b1, 1'b1, LE_LF, n_fe, 8'h00);
            end else begin
                s_rec[1] = make_rec(KIND_CHAR, v_fpos, n_chars, n_u16, v_cp,
                                    1'b0, i_eob, LE_NONE, n_fe, 8'h00);
            end
            s_v[1]   = 1'b1;
            n_chars  = sat_inc(n_chars);
            n_u16    = u16_add(n_u16, (v_flen == 3'd4) ? 2'd2 : 2'd1);
            n_need   = 2'd0;
            n_seqlen = 3'd0;
            n_part   = '0;
        end

        // Close the buffer: summary, then back to the reset state
        if (i_eob) begin
            s_rec[2]   = make_rec(KIND_SUMMARY, n_bytes, n_chars, n_u16, 21'd0,
                                  1'b0, 1'b0, LE_NONE, n_fe, 8'h00);
            s_v[2]     = 1'b1;
            n_crp      = 1'b0;
            n_crpos    = '0;
            n_need     = 2'd0;
            n_seqlen   = 3'd0;
            n_part     = '0;
            n_lead     = '0;
            n_lead_pos = '0;
            n_bytes    = '0;
            n_chars    = '0;
            n_u16      = '0;
            n_fe       = FE_NONE;
            n_err      = 1'b0;
        end
    end

    // Pack the live slots to the front and flag the final one
    always_comb begin
        o_recs = '0;
        v_cnt  = 2'd0;
        for (int i = 0; i < MAX_PUSH; i++) begin
            if (s_v[i]) begin
                o_recs[v_cnt] = s_rec[i];
                v_cnt         = v_cnt + 2'd1;
            end
        end
        if (v_cnt != 2'd0) begin
            o_recs[v_cnt - 2'd1][REC_W-1] = 1'b1;
        end
        o_push_cnt = i_take ? v_cnt : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crp      <= 1'b0;
            r_crpos    <= '0;
            r_need     <= 2'd0;
            r_seqlen   <= 3'd0;
            r_part     <= '0;
            r_lead     <= '0;
            r_lead_pos <= '0;
            r_bytes    <= '0;
            r_chars    <= '0;
            r_u16      <= '0;
            r_fe       <= FE_NONE;
            r_err      <= 1'b0;
        end else if (i_take) begin
            r_crp      <= n_crp;
            r_crpos    <= n_crpos;
            r_need     <= n_need;
            r_seqlen   <= n_seqlen;
            r_part     <= n_part;
            r_lead     <= n_lead;
            r_lead_pos <= n_lead_pos;
            r_bytes    <= n_bytes;
            r_chars    <= n_chars;
            r_u16      <= n_u16;
            r_fe       <= n_fe;
            r_err      <= n_err;
        end
    end

endmodule

`default_nettype wire

### hdl/u8les_fifo.sv
// Small result queue: takes up to three records per cycle, hands out one.
`timescale 1ns / 1ps
`default_nettype none

module u8les_fifo
    import u8les_pkg::*;
#(
    parameter int WIDTH = 112
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [1:0]                     i_push_cnt,
    input  wire logic [MAX_PUSH-1:0][WIDTH-1:0] i_recs,
    input  wire logic                           i_pop,
    output logic                                o_room,
    output logic                                o_valid,
    output logic      [WIDTH-1:0]               o_data
);

    localparam logic [QPTR_W:0] ROOM_LIMIT = (QPTR_W + 1)'(QDEPTH - MAX_PUSH);

    logic [WIDTH-1:0]  r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QPTR_W:0]   r_count, n_count;
    logic              w_pop;

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= ROOM_LIMIT);
    assign o_data  = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr + QPTR_W'(i_push_cnt);
        n_rd    = r_rd + QPTR_W'(w_pop);
        n_count = r_count + (QPTR_W + 1)'(i_push_cnt) - (QPTR_W + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_PUSH; i++) begin
            if (2'(i) < i_push_cnt) begin
                r_mem[r_wr + QPTR_W'(i)] <= i_recs[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

### hdl/utf8_line_eol_scanner.sv
// A byte's records are written into the result queue at its transfer; the queue outputs are registered.
// Throughput: one byte per cycle while each byte yields at most one record and i_m_tready stays high.
// A byte yielding two or three records (CRLF pair, summary) holds tready low
// until the four-entry result queue has room for three records again.
// Reset: synchronous, active low; clears decode state, counters and the queue.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module utf8_line_eol_scanner
    import u8les_pkg::*;
#(
    parameter int POSITION_BITS = 24,
    localparam int FLD_W = 3 * POSITION_BITS + 37,
    localparam int TD_W  = ((FLD_W + 7) / 8) * 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    // Input byte stream
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire logic [7:0]      i_s_tdata,   // [7:0] data_byte
    input  wire logic            i_s_tlast,   // end_of_buffer
    // Result stream
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    // from bit 0 up: byte_pos, char_pos, utf16_pos, code_point, is_line_break,
    // closes_line, line_ending, file_ending, bad_byte, zero pad
    output logic [TD_W-1:0]      o_m_tdata,
    output logic [1:0]           o_m_tuser,   // kind
    output logic                 o_m_tlast    // last_of_run
);

    localparam int REC_W  = FLD_W + 3;
    localparam int CP_LO  = 3 * POSITION_BITS + 1;
    localparam int CP_HI  = CP_LO + 20;
    localparam int BAD_LO = 3 * POSITION_BITS + 29;
    localparam int BAD_HI = BAD_LO + 7;

    logic                           w_s_accept;
    logic [1:0]                     w_push_cnt;
    logic [MAX_PUSH-1:0][REC_W-1:0] w_recs;
    logic [REC_W-1:0]               w_head;
    logic                           w_room;

    // A byte transfers only when the queue can absorb its worst case
    assign o_s_tready = w_room;
    assign w_s_accept = i_s_tvalid && o_s_tready;

    // Decode the byte and build its records in the same cycle as the transfer
    u8les_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_s_accept),
        .i_byte     (i_s_tdata),
        .i_eob      (i_s_tlast),
        .o_push_cnt (w_push_cnt),
        .o_recs     (w_recs)
    );

    // Hold finished records until the consumer takes them
    u8les_fifo #(
        .WIDTH (REC_W)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_recs     (w_recs),
        .i_pop      (i_m_tready),
        .o_room     (w_room),
        .o_valid    (o_m_tvalid),
        .o_data     (w_head)
    );

    // Record layout: {last, kind, fields}; pad the fields to whole bytes
    assign o_m_tdata = TD_W'(w_head[FLD_W-1:0]);
    assign o_m_tuser = w_head[REC_W-2:REC_W-3];
    assign o_m_tlast = w_head[REC_W-1];

    // The buffer's final byte always leaves its summary queued
    `ASSERT_NEXT(a_eob_summary, i_clk, i_rst_n, w_s_accept && i_s_tlast, o_m_tvalid, "summary not queued after final byte")
    // The summary closes the run of its byte
    `ASSERT_IMPLY(a_summary_last, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == KIND_SUMMARY), o_m_tlast, "summary without tlast")
    // Error records carry no code point
    `ASSERT_IMPLY(a_error_no_cp, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == KIND_ERROR), o_m_tdata[CP_HI:CP_LO] == '0, "error record with code point")
    // Character records carry no bad byte
    `ASSERT_IMPLY(a_char_no_bad, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == KIND_CHAR), o_m_tdata[BAD_HI:BAD_LO] == '0, "character record with bad byte")

endmodule

`default_nettype wire

### bench/utf8_line_eol_scanner_tb.sv
// Self-checking testbench for the UTF-8 line and line-ending scanner.
`timescale 1ns / 1ps

module utf8_line_eol_scanner_tb;
    import u8les_pkg::*;

    localparam int          REC_W        = 112;       // result tdata width, padded to bytes
    localparam logic [23:0] POS_MAX      = 24'hFFFFFF;
    localparam logic [24:0] U16_MAX      = 25'h1FFFFFF;
    localparam int          RANDOM_BYTES = 450;       // scanned (not ignored) bytes to send
    localparam int          DRAIN_CYCLES = 20;
    localparam int          LIMIT_CYCLES = 400000;

    // One expected result, field by field.
    typedef struct {
        t_kind       kind;
        logic [23:0] byte_pos;
        logic [23:0] char_pos;
        logic [24:0] utf16_pos;
        logic [20:0] code_point;
        logic        is_break;
        logic        closes;
        logic [1:0]  line_eol;
        logic [2:0]  file_eol;
        logic [7:0]  bad;
        logic        last;
    } t_scan_rec;

    // Scoreboard: decodes each accepted byte on its own copy of the scanner state and
    // queues the records that byte must produce, then checks records in arrival order.
    class line_scan_scoreboard;
        t_scan_rec   expected_records[$];
        t_scan_rec   batch[$];
        int unsigned errors;
        int unsigned live_bytes;

        bit          cr_held;
        logic [23:0] cr_at;
        int          need;
        int          seq_len;
        logic [20:0] code;
        logic [7:0]  lead;
        logic [23:0] lead_at;
        logic [23:0] n_bytes;
        logic [23:0] n_chars;
        logic [24:0] n_units;
        logic [2:0]  file_eol;
        bit          failed;

        function new();
            errors     = 0;
            live_bytes = 0;
            clear_all();
        endfunction

        function void clear_seq();
            need    = 0;
            seq_len = 0;
            code    = '0;
        endfunction

        function void clear_all();
            cr_held  = 1'b0;
            cr_at    = '0;
            clear_seq();
            lead     = '0;
            lead_at  = '0;
            n_bytes  = '0;
            n_chars  = '0;
            n_units  = '0;
            file_eol = FE_NONE;
            failed   = 1'b0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 40) $display("ERROR at %0t: %s", $time, msg);
        endfunction

        function int pending();
            return expected_records.size();
        endfunction

        function void emit(t_kind k, logic [23:0] bpos, logic [20:0] cp, logic brk,
                           logic cl, logic [1:0] le, logic [7:0] bad);
            t_scan_rec r;
            r.kind       = k;
            r.byte_pos   = bpos;
            r.char_pos   = n_chars;
            r.utf16_pos  = n_units;
            r.code_point = cp;
            r.is_break   = brk;
            r.closes     = cl;
            r.line_eol   = le;
            r.file_eol   = file_eol;
            r.bad        = bad;
            r.last       = 1'b0;
            batch.insert(batch.size(), r);
        endfunction

        // Fold a line ending into the file-wide type; any second kind makes it hybrid.
        function void merge_eol(logic [2:0] e);
            if (file_eol == FE_NONE) file_eol = e;
            else if (file_eol != FE_HYBRID && file_eol != e) file_eol = FE_HYBRID;
        endfunction

        // Advance character and UTF-16 counters, saturating.
        function void count_char(int units);
            if (n_chars != POS_MAX) n_chars++;
            if ({1'b0, n_units} + 26'(units) > {1'b0, U16_MAX}) n_units = U16_MAX;
            else n_units = n_units + 25'(units);
        endfunction

        function void raise_error(logic [7:0] bad, logic [23:0] bpos);
            emit(KIND_ERROR, bpos, '0, 1'b0, 1'b0, LE_NONE, bad);
            failed = 1'b1;
            clear_seq();
        endfunction

        function void close_char(logic [20:0] cp, logic [23:0] bpos, int len, bit eob);
            if (cp == CP_LF) begin
                merge_eol(FE_LF);
                emit(KIND_CHAR, bpos, cp, 1'b1, 1'b1, LE_LF, '0);
            end else begin
                // the buffer end closes the last line without an ending
                emit(KIND_CHAR, bpos, cp, 1'b0, eob, LE_NONE, '0);
            end
            count_char(len == 4 ? 2 : 1);
            clear_seq();
        endfunction

        function void decode(logic [7:0] b, logic [23:0] pos, bit eob);
            int          n;
            logic [20:0] c;
            logic [7:0]  lo;
            logic [7:0]  hi;
            if (need == 0) begin
                if (b == CH_CR) begin
                    if (eob) begin
                        merge_eol(FE_CR);
                        emit(KIND_CHAR, pos, CP_CR, 1'b1, 1'b1, LE_CR, '0);
                        count_char(1);
                    end else begin
                        // hold the CR until the next byte tells CR from CRLF
                        cr_held = 1'b1;
                        cr_at   = pos;
                    end
                    return;
                end
                if (b >= 8'h01 && b <= 8'h7F) begin
                    close_char({13'd0, b}, pos, 1, eob);
                    return;
                end
                if (b >= 8'hC2 && b <= 8'hDF) begin
                    n = 1;
                    c = {16'd0, b[4:0]};
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    n = 2;
                    c = {17'd0, b[3:0]};
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    n = 3;
                    c = {18'd0, b[2:0]};
                end else begin
                    // NUL, stray continuation, C0/C1, F5 and up
                    raise_error(b, pos);
                    return;
                end
                lead    = b;
                lead_at = pos;
                seq_len = n + 1;
                need    = n;
                code    = c;
                if (eob) raise_error(lead, lead_at);
            end else begin
                lo = 8'h80;
                hi = 8'hBF;
                // the first continuation byte rules out overlongs, surrogates and > 10FFFF
                if (need + 1 == seq_len) begin
                    case (lead)
                        8'hE0: lo = 8'hA0;
                        8'hED: hi = 8'h9F;
                        8'hF0: lo = 8'h90;
                        8'hF4: hi = 8'h8F;
                        default: ;
                    endcase
                end
                if (b < lo || b > hi) begin
                    raise_error(lead, lead_at);
                    return;
                end
                code = {code[14:0], b[5:0]};
                need--;
                if (need == 0) begin
                    if (code == CP_REPL) raise_error(lead, lead_at);
                    else close_char(code, lead_at, seq_len, eob);
                end else if (eob) begin
                    raise_error(lead, lead_at);
                end
            end
        endfunction

        // Note one accepted byte and queue the records it causes.
        function void note_byte(logic [7:0] b, bit eob);
            logic [23:0] pos;
            batch.delete();
            pos = n_bytes;
            if (n_bytes != POS_MAX) n_bytes++;
            if (!failed) begin
                live_bytes++;
                if (cr_held) begin
                    cr_held = 1'b0;
                    if (b == CH_LF) begin
                        // CRLF: both records share the CR's character indices
                        merge_eol(FE_CRLF);
                        emit(KIND_CHAR, cr_at, CP_CR, 1'b1, 1'b0, LE_NONE, '0);
                        emit(KIND_CHAR, pos, CP_LF, 1'b1, 1'b1, LE_CRLF, '0);
                        count_char(1);
                    end else begin
                        merge_eol(FE_CR);
                        emit(KIND_CHAR, cr_at, CP_CR, 1'b1, 1'b1, LE_CR, '0);
                        count_char(1);
                        decode(b, pos, eob);
                    end
                end else begin
                    decode(b, pos, eob);
                end
            end
            if (eob) begin
                emit(KIND_SUMMARY, n_bytes, '0, 1'b0, 1'b0, LE_NONE, '0);
                clear_all();
            end
            if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i]) expected_records.insert(expected_records.size(), batch[i]);
        endfunction

        function void compare(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s: got 0x%0h, expected 0x%0h", field, got, want));
        endfunction

        // Check one result transfer against the oldest expected record.
        function void check_record(logic [1:0] kind, logic [REC_W-1:0] d, logic last);
            t_scan_rec e;
            if (expected_records.size() == 0) begin
                report($sformatf("unexpected record: kind %0d tdata 0x%0h", kind, d));
                return;
            end
            e = expected_records.pop_front();
            compare("kind",          kind,          e.kind);
            compare("byte_pos",      d[23:0],       e.byte_pos);
            compare("char_pos",      d[47:24],      e.char_pos);
            compare("utf16_pos",     d[72:48],      e.utf16_pos);
            compare("code_point",    d[93:73],      e.code_point);
            compare("is_line_break", d[94],         e.is_break);
            compare("closes_line",   d[95],         e.closes);
            compare("line_ending",   d[97:96],      e.line_eol);
            compare("file_ending",   d[100:98],     e.file_eol);
            compare("bad_byte",      d[108:101],    e.bad);
            compare("tdata pad",     d[REC_W-1:109], '0);
            compare("last_of_run",   last,          e.last);
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [7:0]       i_s_tdata  = '0;     // [7:0] data_byte
    logic             i_s_tlast  = 1'b0;   // end_of_buffer
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [REC_W-1:0] o_m_tdata;           // byte_pos .. bad_byte, zero pad (bit 0 up)
    logic [1:0]       o_m_tuser;           // kind
    logic             o_m_tlast;           // last_of_run

    line_scan_scoreboard board;
    bit                  quiet = 1'b0;     // set: neither side inserts gaps
    int unsigned         cycles = 0;
    logic [7:0]          buf_q[$];

    utf8_line_eol_scanner u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] tail_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // Add one byte at the end of a buffer under construction.
    function automatic void put_byte(ref logic [7:0] q[$], input logic [7:0] b);
        q.insert(q.size(), b);
    endfunction

    // Append one well-formed character, line breaks weighted up.
    function automatic void add_valid_char(ref logic [7:0] q[$]);
        int         r;
        logic [7:0] ld;
        logic [7:0] b2;
        logic [7:0] b3;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            put_byte(q, CH_CR);
        end else if (r < 24) begin
            put_byte(q, CH_LF);
        end else if (r < 50) begin
            put_byte(q, 8'($urandom_range(1, 127)));
        end else if (r < 68) begin
            put_byte(q, 8'($urandom_range(8'hC2, 8'hDF)));
            put_byte(q, tail_byte());
        end else if (r < 86) begin
            ld = 8'($urandom_range(8'hE0, 8'hEF));
            case (ld)
                8'hE0:   b2 = 8'($urandom_range(8'hA0, 8'hBF));
                8'hED:   b2 = 8'($urandom_range(8'h80, 8'h9F));
                default: b2 = tail_byte();
            endcase
            b3 = tail_byte();
            if (ld == 8'hEF && b2 == 8'hBF && b3 == 8'hBD) b3 = 8'hBE;   // keep clear of U+FFFD
            put_byte(q, ld);
            put_byte(q, b2);
            put_byte(q, b3);
        end else begin
            ld = 8'($urandom_range(8'hF0, 8'hF4));
            case (ld)
                8'hF0:   b2 = 8'($urandom_range(8'h90, 8'hBF));
                8'hF4:   b2 = 8'($urandom_range(8'h80, 8'h8F));
                default: b2 = tail_byte();
            endcase
            put_byte(q, ld);
            put_byte(q, b2);
            put_byte(q, tail_byte());
            put_byte(q, tail_byte());
        end
    endfunction

    // Append one malformed sequence.
    function automatic void add_bad_char(ref logic [7:0] q[$]);
        logic [7:0] junk;
        junk = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8'h7F))
                                           : 8'($urandom_range(8'hC0, 8'hFF));
        case ($urandom_range(0, 10))
            0: put_byte(q, 8'h00);
            1: begin
                put_byte(q, 8'($urandom_range(8'hC0, 8'hC1)));
                put_byte(q, tail_byte());
            end
            2: put_byte(q, 8'($urandom_range(8'hF5, 8'hFF)));
            3: put_byte(q, tail_byte());
            4: begin   // overlong three-byte form
                put_byte(q, 8'hE0);
                put_byte(q, 8'($urandom_range(8'h80, 8'h9F)));
                put_byte(q, tail_byte());
            end
            5: begin   // surrogate
                put_byte(q, 8'hED);
                put_byte(q, 8'($urandom_range(8'hA0, 8'hBF)));
                put_byte(q, tail_byte());
            end
            6: begin   // overlong four-byte form
                put_byte(q, 8'hF0);
                put_byte(q, 8'($urandom_range(8'h80, 8'h8F)));
                put_byte(q, tail_byte());
                put_byte(q, tail_byte());
            end
            7: begin   // above 10FFFF
                put_byte(q, 8'hF4);
                put_byte(q, 8'($urandom_range(8'h90, 8'hBF)));
                put_byte(q, tail_byte());
                put_byte(q, tail_byte());
            end
            8: begin   // U+FFFD
                put_byte(q, 8'hEF);
                put_byte(q, 8'hBF);
                put_byte(q, 8'hBD);
            end
            9: begin   // lead without continuation
                put_byte(q, 8'($urandom_range(8'hC2, 8'hF4)));
                put_byte(q, junk);
            end
            default: begin   // fault on a later continuation
                put_byte(q, 8'($urandom_range(8'hF1, 8'hF3)));
                put_byte(q, tail_byte());
                put_byte(q, junk);
            end
        endcase
    endfunction

    // Append a sequence that the buffer end cuts short.
    function automatic void add_cut_char(ref logic [7:0] q[$]);
        int k;
        case ($urandom_range(0, 2))
            0: begin
                put_byte(q, 8'($urandom_range(8'hC2, 8'hDF)));
                k = 0;
            end
            1: begin
                put_byte(q, 8'($urandom_range(8'hE1, 8'hEC)));
                k = $urandom_range(0, 1);
            end
            default: begin
                put_byte(q, 8'($urandom_range(8'hF1, 8'hF3)));
                k = $urandom_range(0, 2);
            end
        endcase
        repeat (k) put_byte(q, tail_byte());
    endfunction

    // Build one buffer: mostly valid text, sometimes a fault or a cut-short tail.
    function automatic void build_buffer(ref logic [7:0] q[$]);
        int n_char;
        int bad_at;
        q.delete();
        n_char = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        bad_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n_char - 1) : -1;
        for (int i = 0; i < n_char; i++) begin
            if (i == bad_at) add_bad_char(q);
            else add_valid_char(q);
        end
        if ($urandom_range(0, 7) == 0) add_cut_char(q);
    endfunction

    // Offer one byte and hold it until the transfer; valid stays high for the next call.
    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_byte(b, last);
    endtask

    task automatic send_buffer(input logic [7:0] q[$]);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    // Result side: random stalls, with quiet stretches of steady ready.
    initial begin
        int run;
        int gap;
        forever begin
            run = $urandom_range(1, 12);
            i_m_tready <= 1'b1;
            repeat (run) @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    end

    // Check every result transfer; values are sampled before this edge's updates.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_record(o_m_tuser, o_m_tdata, o_m_tlast);
    end

    // Watchdog: a stuck handshake or a missing record ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            board.report($sformatf("timeout, %0d records still expected", board.pending()));
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        board = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ASCII extremes, two-byte bounds, lowest three-byte value, CRLF, lone CR, CR as last byte
        buf_q = '{8'h01, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'h0D, 8'h0A, 8'h0D,
                  8'hE0, 8'hA0, 8'h80, 8'h0D};
        send_buffer(buf_q);
        // highest scalar value, then LF as the last byte
        buf_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h0A};
        send_buffer(buf_q);
        // U+FFFD is rejected on its final byte
        buf_q = '{8'hEF, 8'hBF, 8'hBD};
        send_buffer(buf_q);
        // lone CR before a stray continuation; the byte after the error is dropped
        buf_q = '{8'h0D, 8'h80, 8'h41};
        send_buffer(buf_q);
        // four-byte sequence cut short by the buffer end
        buf_q = '{8'hF0, 8'h90};
        send_buffer(buf_q);

        // Random buffers; a fifth of them run with no gaps on either side.
        while (board.live_bytes < RANDOM_BYTES) begin
            quiet = ($urandom_range(0, 4) == 0);
            build_buffer(buf_q);
            send_buffer(buf_q);
        end
        quiet = 1'b0;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        // Drain, then give stray records a chance to show up.
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
